FILE: sv/vertex_dedup_indexer_top_defines.svh
// ----------------------------------------------------------------------------
// Vertex dedup indexer assertion macros
// Shared assertion forms used by the top level of the vertex dedup indexer.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define VDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define VDI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/vdi_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Widths, result codes and types shared by the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int VERTEX_COMPONENTS = 8;
  localparam int COMP_W            = 32;
  localparam int TOL_W             = 16;
  localparam int INDEX_W           = 8;
  localparam int OUTCOME_W         = 2;
  localparam int MAX_VERTICES_DEF  = 256;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

  localparam logic [OUTCOME_W-1:0] OUT_MATCH  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_APPEND = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FULL   = 2'd2;

  typedef logic signed [COMP_W-1:0]                    comp_t;
  typedef logic [VERTEX_COMPONENTS-1:0][COMP_W-1:0]    vertex_t;
  typedef logic [TOL_W-1:0]                            tol_t;
  typedef logic [OUTCOME_W-1:0]                        outcome_t;

endpackage

FILE: sv/vdi_if.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer channels
// Valid/ready channels for vertex input, index results and the tolerance write.
// ----------------------------------------------------------------------------
interface vdi_in_if import vdi_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t comp_0;
  comp_t comp_1;
  comp_t comp_2;
  comp_t comp_3;
  comp_t comp_4;
  comp_t comp_5;
  comp_t comp_6;
  comp_t comp_7;

  modport source (output valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5, comp_6,
                  comp_7, input ready);
  modport sink (input valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5, comp_6,
                comp_7, output ready);
endinterface

interface vdi_out_if import vdi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] vertex_index;
  outcome_t           outcome;

  modport source (output valid, vertex_index, outcome, input ready);
  modport sink (input valid, vertex_index, outcome, output ready);
endinterface

interface vdi_cfg_if import vdi_pkg::*; ();
  logic valid;
  logic ready;
  tol_t match_tolerance;

  modport source (output valid, match_tolerance, input ready);
  modport sink (input valid, match_tolerance, output ready);
endinterface

FILE: sv/vdi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/vdi_match.sv
// ----------------------------------------------------------------------------
// Vertex match unit
// Compares one stored vertex against the incoming one, all components at once.
// ----------------------------------------------------------------------------
module vdi_match import vdi_pkg::*; (
  input  vertex_t vtx,
  input  vertex_t stored,
  input  tol_t    tol,
  output logic    match
);

  logic [VERTEX_COMPONENTS-1:0] close;

  for (genvar c = 0; c < VERTEX_COMPONENTS; c++) begin : g_comp
    logic signed [COMP_W:0] diff;
    logic        [COMP_W:0] mag;

    // The difference is exact in one extra bit, so its magnitude never wraps.
    always_comb begin
      diff     = {vtx[c][COMP_W-1], vtx[c]} - {stored[c][COMP_W-1], stored[c]};
      mag      = diff[COMP_W] ? (~diff + 1'b1) : diff;
      close[c] = mag < {{(COMP_W+1-TOL_W){1'b0}}, tol};
    end
  end

  assign match = &close;

endmodule

FILE: sv/vertex_dedup_indexer_top.sv
// Search: the stored entries are scanned in index order, one stored entry read per cycle, and
// the shared match unit checks each entry in the cycle after its read; the first match wins,
// and with no match the vertex is appended or reported full. A new vertex is accepted only
// once the result of the previous one has been loaded into the output beat.
// Reset: synchronous; clears the vertex count, the sequencer and the output beat, and sets
// the tolerance to 655. The vertex RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// Vertex dedup indexer top level
// Finds or appends a vertex in the unique vertex table and returns its index.
// ----------------------------------------------------------------------------
`include "vertex_dedup_indexer_top_defines.svh"

module vertex_dedup_indexer_top import vdi_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  vdi_cfg_if.sink   cfg,
  vdi_in_if.sink    vin,
  vdi_out_if.source vout
);

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int ROW_W = VERTEX_COMPONENTS * COMP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]       state;
  tol_t             tol;
  vertex_t          vtx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             pend;
  logic [IDX_W-1:0] res_idx;
  outcome_t         res_out;
  logic             out_valid;
  logic [INDEX_W-1:0] out_index;
  outcome_t         out_outcome;

  logic             rd_en;
  logic             hit;
  logic             decide;
  logic             is_full;
  logic             wr_en;
  logic [ROW_W-1:0] rd_row;
  vertex_t          stored;
  logic             match;
  logic [IDX_W+INDEX_W-1:0] idx_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg.valid) begin
      tol <= cfg.match_tolerance;
    end
  end

  always_comb begin
    rd_en   = (state == ST_SEARCH) && (rd_idx < count);
    hit     = (state == ST_SEARCH) && pend && match;
    decide  = (state == ST_SEARCH) && !pend && !(rd_idx < count);
    is_full = (count == CNT_W'(MAX_VERTICES));
    wr_en   = decide && !is_full;
    idx_ext = {{INDEX_W{1'b0}}, res_idx};
  end

  vdi_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (vtx),
    .re    (rd_en),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_row)
  );

  assign stored = rd_row;

  vdi_match u_match (
    .vtx    (vtx),
    .stored (stored),
    .tol    (tol),
    .match  (match)
  );

  assign vin.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (vin.valid) begin
            state  <= ST_SEARCH;
            rd_idx <= '0;
            pend   <= 1'b0;
          end
        end
        ST_SEARCH: begin
          priority if (hit) begin
            res_idx <= cmp_idx;
            res_out <= OUT_MATCH;
            state   <= ST_DONE;
          end else if (decide) begin
            if (is_full) begin
              res_idx <= '0;
              res_out <= OUT_FULL;
            end else begin
              res_idx <= count[IDX_W-1:0];
              res_out <= OUT_APPEND;
              count   <= count + 1'b1;
            end
            state <= ST_DONE;
          end else begin
            pend    <= rd_en;
            cmp_idx <= rd_idx[IDX_W-1:0];
            rd_idx  <= rd_idx + CNT_W'(rd_en);
          end
        end
        ST_DONE: begin
          if (!out_valid || vout.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vin.valid && vin.ready) begin
      vtx <= {vin.comp_7, vin.comp_6, vin.comp_5, vin.comp_4,
              vin.comp_3, vin.comp_2, vin.comp_1, vin.comp_0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || vout.ready)) begin
      out_valid   <= 1'b1;
      out_index   <= idx_ext[INDEX_W-1:0];
      out_outcome <= res_out;
    end else if (vout.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign vout.valid        = out_valid;
  assign vout.vertex_index = out_index;
  assign vout.outcome      = out_outcome;

  `VDI_ASSERT(a_count_bound, count <= CNT_W'(MAX_VERTICES), "vertex count beyond table size")
  `VDI_ASSERT(a_count_step, (!$past(rst) && count != $past(count)) |-> (count == $past(count) + 1'b1), "vertex count moved by other than one")
  `VDI_ASSERT(a_read_in_range, rd_en |-> (rd_idx < count), "read of an entry not yet written")
  `VDI_ASSERT_ALWAYS(a_busy_no_accept, (state != ST_IDLE) |-> !vin.ready, "input accepted while busy")

endmodule

FILE: tb/vdi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex dedup indexer checker
// Watches the tolerance, vertex and index channels, keeps its own copy of the
// unique vertex table and compares every index beat with the lookup predicted
// for the oldest vertex still waiting for its result.
// ----------------------------------------------------------------------------
module vdi_checker import vdi_pkg::*; #(
  parameter int CAPACITY = MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst,
  vdi_cfg_if   cfg,
  vdi_in_if    vin,
  vdi_out_if   vout,
  output int   mismatches,
  output int   outstanding,
  output int   stored
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    outcome_t           outcome;
  } lookup_t;

  localparam int REPORT_CAP = 40;

  vertex_t   known_vertices [CAPACITY];
  int        vertex_count;
  tol_t      tolerance;
  lookup_t   lookups_due [$];

  function automatic bit comp_close(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b, tol_t tol);
    longint diff;
    diff = longint'(comp_t'(a)) - longint'(comp_t'(b));
    if (diff < 0) begin
      diff = -diff;
    end
    return diff < longint'(tol);
  endfunction

  // First stored vertex in insertion order wins; an unmatched vertex is
  // appended unless the table is already full.
  function automatic lookup_t find_or_append(vertex_t v);
    lookup_t r;
    bit      hit;
    for (int i = 0; i < vertex_count; i++) begin
      hit = 1'b1;
      for (int c = 0; c < VERTEX_COMPONENTS; c++) begin
        if (!comp_close(v[c], known_vertices[i][c], tolerance)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        r.index   = INDEX_W'(i);
        r.outcome = OUT_MATCH;
        return r;
      end
    end
    if (vertex_count >= CAPACITY) begin
      r.index   = '0;
      r.outcome = OUT_FULL;
      return r;
    end
    known_vertices[vertex_count] = v;
    r.index   = INDEX_W'(vertex_count);
    r.outcome = OUT_APPEND;
    vertex_count++;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    vertex_t v;
    int      errs;
    errs = 0;
    if (rst) begin
      tolerance    = TOL_RESET;
      vertex_count = 0;
      lookups_due.delete();
      mismatches  <= 0;
      outstanding <= 0;
      stored      <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        tolerance = cfg.match_tolerance;
      end
      if (vout.valid && vout.ready) begin
        if (lookups_due.size() == 0) begin
          errs++;
          if (mismatches < REPORT_CAP) begin
            $display("%0t: unexpected index beat, vertex_index %0d outcome %0d",
                     $time, vout.vertex_index, vout.outcome);
          end
        end else begin
          want = lookups_due.pop_front();
          if (vout.vertex_index !== want.index) begin
            errs++;
            if (mismatches < REPORT_CAP) begin
              $display("%0t: vertex_index expected %0d actual %0d",
                       $time, want.index, vout.vertex_index);
            end
          end
          if (vout.outcome !== want.outcome) begin
            errs++;
            if (mismatches < REPORT_CAP) begin
              $display("%0t: outcome expected %0d actual %0d",
                       $time, want.outcome, vout.outcome);
            end
          end
        end
      end
      if (vin.valid && vin.ready) begin
        v = {vin.comp_7, vin.comp_6, vin.comp_5, vin.comp_4,
             vin.comp_3, vin.comp_2, vin.comp_1, vin.comp_0};
        lookups_due = {lookups_due, find_or_append(v)};
      end
      mismatches  <= mismatches + errs;
      outstanding <= lookups_due.size();
      stored      <= vertex_count;
    end
  end

endmodule

FILE: tb/vertex_dedup_indexer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex dedup indexer testbench
// Drives directed and random vertices through the dedup indexer under several
// tolerances, fills the table to capacity, and lets a separate checker predict
// and compare every index beat while both ends idle and stall at random.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_top_tb;
  import vdi_pkg::*;

  localparam int CAPACITY    = MAX_VERTICES_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = CAPACITY + 8;

  logic clk;
  logic rst;

  vdi_cfg_if cfg_ch ();
  vdi_in_if  vin_ch ();
  vdi_out_if vout_ch ();

  int mismatches;
  int outstanding;
  int stored;

  vertex_t pool [$];
  tol_t    cur_tol;
  int      burst_left;
  int      idle_cycles;
  int      beats_out;
  bit      hold_done;

  vertex_dedup_indexer_top dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .vin  (vin_ch),
    .vout (vout_ch)
  );

  vdi_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .vin         (vin_ch),
    .vout        (vout_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .stored      (stored)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic vertex_t splat(logic [COMP_W-1:0] x);
    vertex_t v;
    for (int c = 0; c < VERTEX_COMPONENTS; c++) begin
      v[c] = x;
    end
    return v;
  endfunction

  function automatic vertex_t fresh_vertex();
    vertex_t v;
    int      flavour;
    flavour = $urandom_range(0, 2);
    for (int c = 0; c < VERTEX_COMPONENTS; c++) begin
      case (flavour)
        0: begin
          v[c] = $urandom;
        end
        1: begin
          v[c] = COMP_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        end
        default: begin
          case ($urandom_range(0, 4))
            0: v[c] = 32'h7FFF_FFFF;
            1: v[c] = 32'h8000_0000;
            2: v[c] = 32'h0000_0000;
            3: v[c] = 32'hFFFF_FFFF;
            default: v[c] = $urandom;
          endcase
        end
      endcase
    end
    return v;
  endfunction

  // Near copies of earlier vertices: either every component inside the
  // tolerance, or one component pushed onto or just past its edge.
  function automatic vertex_t near_vertex(bit on_edge);
    vertex_t v;
    int      lim;
    int      d;
    int      pick;
    v    = pool[$urandom_range(0, pool.size() - 1)];
    lim  = (int'(cur_tol) > 0) ? int'(cur_tol) - 1 : 0;
    pick = $urandom_range(0, VERTEX_COMPONENTS - 1);
    for (int c = 0; c < VERTEX_COMPONENTS; c++) begin
      if (on_edge && c == pick) begin
        d = int'(cur_tol) + int'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
          d = -d;
        end
      end else begin
        d = int'($urandom_range(0, 2 * lim)) - lim;
      end
      v[c] = v[c] + COMP_W'(d);
    end
    return v;
  endfunction

  function automatic vertex_t mixed_vertex();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      return pool[$urandom_range(0, pool.size() - 1)];
    end else if (roll < 60) begin
      return near_vertex(1'b0);
    end else if (roll < 75) begin
      return near_vertex(1'b1);
    end
    return fresh_vertex();
  endfunction

  task automatic put_vertex(input vertex_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        vin_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    vin_ch.valid  <= 1'b1;
    vin_ch.comp_0 <= v[0];
    vin_ch.comp_1 <= v[1];
    vin_ch.comp_2 <= v[2];
    vin_ch.comp_3 <= v[3];
    vin_ch.comp_4 <= v[4];
    vin_ch.comp_5 <= v[5];
    vin_ch.comp_6 <= v[6];
    vin_ch.comp_7 <= v[7];
    do @(posedge clk); while (!vin_ch.ready);
    burst_left--;
    pool = {pool, v};
  endtask

  task automatic drain();
    vin_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input tol_t t);
    drain();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.match_tolerance <= t;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_tol = t;
  endtask

  task automatic run_mixed(input int n);
    repeat (n) put_vertex(mixed_vertex());
  endtask

  // Receiver: random stall modes, each picked anew at random, plus one long
  // hold-off while the sender keeps offering vertices.
  initial begin : receiver
    int mode;
    int slot;
    slot = 0;
    mode = 0;
    vout_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && beats_out >= 40) begin
        vout_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (slot == 0) begin
          mode = $urandom_range(0, 3);
          slot = $urandom_range(16, 96);
        end
        slot--;
        case (mode)
          0: vout_ch.ready <= 1'b1;
          1: vout_ch.ready <= $urandom_range(0, 1);
          2: vout_ch.ready <= ($urandom_range(0, 3) == 0);
          default: vout_ch.ready <= (slot % 5 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((vin_ch.valid && vin_ch.ready) || (vout_ch.valid && vout_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
      if (vout_ch.valid && vout_ch.ready) begin
        beats_out++;
      end
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    vertex_t v;
    burst_left = 0;
    beats_out  = 0;
    hold_done  = 1'b0;
    cur_tol    = TOL_RESET;
    rst                    <= 1'b1;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.match_tolerance <= TOL_RESET;
    vin_ch.valid           <= 1'b0;
    vin_ch.comp_0          <= '0;
    vin_ch.comp_1          <= '0;
    vin_ch.comp_2          <= '0;
    vin_ch.comp_3          <= '0;
    vin_ch.comp_4          <= '0;
    vin_ch.comp_5          <= '0;
    vin_ch.comp_6          <= '0;
    vin_ch.comp_7          <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset tolerance.
    put_vertex(splat(32'h0000_0000));
    put_vertex(splat(32'h7FFF_FFFF));
    put_vertex(splat(32'h8000_0000));
    put_vertex(splat(32'h0000_0000));
    v = splat(32'h0000_0000);
    v[5] = 32'd654;
    put_vertex(v);
    v = splat(32'h0000_0000);
    v[2] = 32'd655;
    put_vertex(v);
    v = splat(32'h0000_0000);
    v[7] = -32'sd654;
    put_vertex(v);
    v = splat(32'h7FFF_FFFF);
    v[0] = 32'h7FFF_FFFF - 32'd654;
    put_vertex(v);
    v = splat(32'h8000_0000);
    v[4] = 32'h8000_0000 + 32'd654;
    put_vertex(v);
    v = splat(32'h8000_0000);
    v[1] = 32'h7FFF_FFFF;
    put_vertex(v);
    put_vertex(splat(32'h5555_5555));
    put_vertex(splat(32'hAAAA_AAAA));
    put_vertex(splat(32'hFFFF_FFFF));
    v = fresh_vertex();
    put_vertex(v);
    put_vertex(v);

    // With a zero tolerance even an exact repeat is appended.
    write_tolerance(16'd0);
    put_vertex(splat(32'h0000_0000));
    put_vertex(splat(32'h0000_0000));

    write_tolerance(16'hFFFF);
    put_vertex(splat(32'd65534));
    put_vertex(splat(32'd65535));
    put_vertex(splat(32'hFFFF_0001));

    write_tolerance(tol_t'($urandom_range(1, 4000)));
    run_mixed(120);

    write_tolerance(tol_t'($urandom_range(0, 65535)));
    run_mixed(80);

    // Fill the table, then keep sending so that dropped vertices appear.
    write_tolerance(16'd0);
    while (stored < CAPACITY) begin
      run_mixed(16);
      drain();
    end
    run_mixed(10);

    write_tolerance(16'hFFFF);
    run_mixed(40);

    write_tolerance(16'd1);
    run_mixed(40);

    write_tolerance(tol_t'($urandom_range(0, 65535)));
    run_mixed(30);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
